// File: rtl/dvwp_pkg.sv
// Shared constants and types for the delta variable-length word packer.
package dvwp_pkg;

  localparam int DVWP_CHANNELS = 16;
  localparam int CHAN_W        = 4;
  localparam int SAMPLE_W      = 32;
  localparam int MODE_W        = 6;
  localparam int WORD_W        = 32;
  localparam int PART_W        = 24;

  // Output word queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Operation codes.
  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Result of coding one sample into the byte stream.
  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [1:0]        nwords;
    logic [1:0]        bp_nxt;
    logic [PART_W-1:0] partial_nxt;
  } pack_t;

  // One entry of the output queue.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } fifo_entry_t;

endpackage

// File: rtl/dvwp_if.sv
// Valid/ready channel interfaces for the sample input and the word output.
interface dvwp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [dvwp_pkg::CHAN_W-1:0]         channel;
  logic signed [dvwp_pkg::SAMPLE_W-1:0] sample;
  logic [dvwp_pkg::MODE_W-1:0]         record_mode;

  modport source (output valid, operation, channel, sample, record_mode, input ready);
  modport sink   (input valid, operation, channel, sample, record_mode, output ready);
endinterface

interface dvwp_out_if;
  logic                        valid;
  logic                        ready;
  logic [dvwp_pkg::WORD_W-1:0] packed_word;
  logic                        last;

  modport source (output valid, packed_word, last, input ready);
  modport sink   (input valid, packed_word, last, output ready);
endinterface

// File: rtl/delta_varlen_word_packer_core.sv
// Top level of the delta variable-length word packer.
// An accepted item waits in the input register until the output queue has room for
// two words; it is then coded and its words are written into the output queue.
// Throughput: one item per cycle while the four-word output queue has room for two words;
// the output drains one word per cycle while the receiver is ready.
// Reset (synchronous, rst_n low) clears channel history, byte position and the output queue.
module delta_varlen_word_packer_core #(
  parameter int CHANNELS = dvwp_pkg::DVWP_CHANNELS
) (
  input  logic       clk,
  input  logic       rst_n,
  dvwp_in_if.sink    in_ch,
  dvwp_out_if.source out_ch
);
  import dvwp_pkg::*;

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CmpW   = ChIdxW + CHAN_W;

  // Input register.
  logic                in_v_r;
  logic                op_r;
  logic [CHAN_W-1:0]   ch_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [MODE_W-1:0]   mode_r;

  // Coding state.
  logic [SAMPLE_W-1:0] prev_r [CHANNELS];
  logic [1:0]          bp_r;
  logic [PART_W-1:0]   partial_r;

  logic                room2;
  logic                advance;
  logic [CmpW-1:0]     ch_ext;
  logic                hit;
  logic [ChIdxW-1:0]   idx;
  logic [SAMPLE_W-1:0] prev;
  pack_t               enc;
  logic [1:0]          wr_cnt;
  fifo_entry_t         wr0, wr1;

  assign advance     = in_v_r && room2;
  assign in_ch.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      op_r     <= in_ch.operation;
      ch_r     <= in_ch.channel;
      sample_r <= in_ch.sample;
      mode_r   <= in_ch.record_mode;
    end
  end

  // Previous value lookup; a channel beyond the table reads as zero.
  assign ch_ext = CmpW'(ch_r);
  assign hit    = (ch_ext < CmpW'(CHANNELS));
  assign idx    = ch_ext[ChIdxW-1:0];
  assign prev   = hit ? prev_r[idx] : '0;

  dvwp_encode u_encode (
    .sample      (sample_r),
    .prev        (prev),
    .record_mode (mode_r),
    .byte_pos    (bp_r),
    .partial     (partial_r),
    .pack        (enc)
  );

  // State update: restart clears, a push stores the sample and the stream remainder.
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && (op_r == OP_RESTART))) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_r[i] <= '0;
      end
      bp_r      <= '0;
      partial_r <= '0;
    end else if (advance) begin
      bp_r      <= enc.bp_nxt;
      partial_r <= enc.partial_nxt;
      if (hit) begin
        prev_r[idx] <= sample_r;
      end
    end
  end

  // Completed words go to the output queue.
  assign wr_cnt    = (advance && (op_r == OP_PUSH)) ? enc.nwords : 2'd0;
  assign wr0.word  = enc.word0;
  assign wr0.last  = (enc.nwords == 2'd1);
  assign wr1.word  = enc.word1;
  assign wr1.last  = 1'b1;

  dvwp_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_cnt (wr_cnt),
    .wr0    (wr0),
    .wr1    (wr1),
    .room2  (room2),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/dvwp_encode.sv
// Delta, record-length choice and byte packing for one sample.
module dvwp_encode (
  input  logic [dvwp_pkg::SAMPLE_W-1:0] sample,
  input  logic [dvwp_pkg::SAMPLE_W-1:0] prev,
  input  logic [dvwp_pkg::MODE_W-1:0]   record_mode,
  input  logic [1:0]                    byte_pos,
  input  logic [dvwp_pkg::PART_W-1:0]   partial,
  output dvwp_pkg::pack_t               pack
);
  import dvwp_pkg::*;

  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W-1:0] d;
  logic                fit1, fit2, fit3, delta_mode;
  logic [39:0]         rec;
  logic [2:0]          rec_len;
  logic [PART_W-1:0]   part_al;
  logic [63:0]         stream;
  logic [3:0]          total;
  logic [1:0]          nwords;
  logic [1:0]          rem;
  logic [63:0]         tail;
  logic [PART_W-1:0]   tail_top;

  // Saturated 32-bit difference.
  always_comb begin
    diff = {sample[SAMPLE_W-1], sample} - {prev[SAMPLE_W-1], prev};
    if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
      d = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      d = diff[SAMPLE_W-1:0];
    end
  end

  // A record fits when all delta bits above bit 3, 11 or 19 repeat the sign bit.
  assign fit1       = (d[31:4]  == {28{d[31]}});
  assign fit2       = (d[31:12] == {20{d[31]}});
  assign fit3       = (d[31:20] == {12{d[31]}});
  assign delta_mode = (record_mode == '0);

  // Build the record left-aligned in 40 bits.
  always_comb begin
    priority if (delta_mode && fit1) begin
      rec     = {2'b11, d[5:0], 32'b0};
      rec_len = 3'd1;
    end else if (delta_mode && fit2) begin
      rec     = {2'b10, d[13:0], 24'b0};
      rec_len = 3'd2;
    end else if (delta_mode && fit3) begin
      rec     = {2'b01, d[21:0], 16'b0};
      rec_len = 3'd3;
    end else begin
      rec     = {2'b00, record_mode, sample};
      rec_len = 3'd5;
    end
  end

  // Append the record behind the pending bytes and split off whole words.
  always_comb begin
    part_al  = partial << {2'd3 - byte_pos, 3'b000};
    stream   = {part_al, 40'b0} | ({rec, 24'b0} >> {byte_pos, 3'b000});
    total    = {2'b00, byte_pos} + {1'b0, rec_len};
    nwords   = total[3] ? 2'd2 : (total[2] ? 2'd1 : 2'd0);
    rem      = total[1:0];
    tail     = stream << {nwords, 5'b00000};
    tail_top = tail[63:40];

    pack.word0       = stream[63:32];
    pack.word1       = stream[31:0];
    pack.nwords      = nwords;
    pack.bp_nxt      = rem;
    pack.partial_nxt = tail_top >> {2'd3 - rem, 3'b000};
  end

endmodule

// File: rtl/dvwp_out_fifo.sv
// Four-word output queue: up to two words in a cycle, one out when ready.
module dvwp_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            wr_cnt,
  input  dvwp_pkg::fifo_entry_t wr0,
  input  dvwp_pkg::fifo_entry_t wr1,
  output logic                  room2,
  dvwp_out_if.source            out_ch
);
  import dvwp_pkg::*;

  fifo_entry_t           mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  pop;

  assign out_ch.valid       = (count_r != '0);
  assign out_ch.packed_word = mem_r[rp_r].word;
  assign out_ch.last        = mem_r[rp_r].last;
  assign pop                = out_ch.valid && out_ch.ready;
  assign room2              = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign count_nxt          = count_r + FIFO_CNT_W'(wr_cnt) - FIFO_CNT_W'(pop);

  // Storage for queued words.
  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem_r[wp_r] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      mem_r[wp_r + 1'b1] <= wr1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + FIFO_PTR_W'(wr_cnt);
      rp_r    <= rp_r + FIFO_PTR_W'(pop);
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/dvwp_checker.sv
// Port-level checks for the word packer and the bind that attaches them.
module dvwp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dvwp_pkg::WORD_W-1:0] out_word,
  input logic                        out_last
);

  // Reset empties the output queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Reset leaves the input register free.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
    else $error("stalled output word changed");

  // The first of two words of an item is always followed by its second.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second word of an item missing");

  // The input only stalls while the output queue holds words.
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with an empty output queue");

endmodule

bind delta_varlen_word_packer_core dvwp_checker u_dvwp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.packed_word),
  .out_last  (out_ch.last)
);

// File: dv/delta_varlen_word_packer_core_tb.sv
// Self-checking testbench for the delta variable-length word packer core.
module delta_varlen_word_packer_core_tb;
  import dvwp_pkg::*;

  localparam int DIRECTED_ROWS = 23;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;

  // One row of directed stimulus; typed rows carry their expected word by hand.
  typedef struct packed {
    logic              op;
    logic [CHAN_W-1:0] ch;
    logic [31:0]       smp;
    logic [MODE_W-1:0] mode;
    logic              typed;
    logic [1:0]        n_words;
    logic [31:0]       word;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   error_count = 0;

  dvwp_in_if  in_bus ();
  dvwp_out_if out_bus ();

  delta_varlen_word_packer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Hand-checked rows come first, straight out of reset, and walk through the
  // saturated deltas; the rest cover the record length boundaries and forced modes.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_PUSH,    4'd0,  32'h1234_5678, 6'h3F, 1'b1, 2'd1, 32'h3F12_3456},
    '{OP_RESTART, 4'd15, 32'hFFFF_FFFF, 6'h3F, 1'b1, 2'd0, 32'h0},
    '{OP_PUSH,    4'd3,  32'h7FFF_FFFF, 6'h00, 1'b1, 2'd1, 32'h007F_FFFF},
    '{OP_PUSH,    4'd4,  32'h8000_0000, 6'h00, 1'b1, 2'd1, 32'hFF00_8000},
    '{OP_PUSH,    4'd3,  32'h8000_0000, 6'h00, 1'b1, 2'd1, 32'h0000_0080},
    '{OP_PUSH,    4'd4,  32'h7FFF_FFFF, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd5,  32'h0000_0000, 6'h00, 1'b1, 2'd0, 32'h0},
    '{OP_PUSH,    4'd6,  32'h0000_000F, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd7,  32'hFFFF_FFF0, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd8,  32'h0000_0010, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd9,  32'hFFFF_FFEF, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd10, 32'h0000_0FFF, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd11, 32'hFFFF_EFFF, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd12, 32'h000F_FFFF, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd13, 32'hFFEF_FFFF, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd14, 32'hFFFF_FFFF, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd15, 32'h00AB_CDEF, 6'h01, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd15, 32'h00AB_CDEF, 6'h3F, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd15, 32'h00AB_CDEE, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd0,  32'hDEAD_BEEF, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_RESTART, 4'd0,  32'h0000_0000, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd0,  32'h5555_5555, 6'h00, 1'b0, 2'd0, 32'h0},
    '{OP_PUSH,    4'd0,  32'hAAAA_AAAA, 6'h2A, 1'b0, 2'd0, 32'h0}
  };

  // Packer state as seen by the predictor.
  logic [31:0]       chan_history [DVWP_CHANNELS];
  logic [1:0]        held_count;
  logic [PART_W-1:0] held_bytes;
  fifo_entry_t       coded_words [$];
  fifo_entry_t       expected_words [$];

  // Side information that travels with the item on the input channel.
  logic        item_typed;
  logic [1:0]  item_n_words;
  logic [31:0] item_word;

  // Appends one byte to the stream and closes a word on every fourth byte.
  task automatic append_byte(input logic [7:0] b);
    fifo_entry_t done;
    if (held_count == 2'd3) begin
      done.word = {held_bytes, b};
      done.last = 1'b0;
      coded_words.push_back(done);
      held_bytes = '0;
      held_count = 2'd0;
    end else begin
      held_bytes = {held_bytes[15:0], b};
      held_count = held_count + 2'd1;
    end
  endtask

  // Codes one accepted item into coded_words and advances the packer state.
  task automatic encode_sample(input logic op, input logic [CHAN_W-1:0] ch,
                               input logic [31:0] smp, input logic [MODE_W-1:0] mode);
    logic [31:0]        prev;
    logic signed [32:0] diff;
    logic [31:0]        delta;
    int                 run;
    coded_words.delete();
    if (op == OP_RESTART) begin
      foreach (chan_history[k]) chan_history[k] = '0;
      held_count = 2'd0;
      held_bytes = '0;
      return;
    end
    prev = chan_history[ch];
    chan_history[ch] = smp;

    // The difference is taken on 33 bits and clamped to the 32-bit range.
    diff = $signed({smp[31], smp}) - $signed({prev[31], prev});
    if (diff[32] != diff[31]) begin
      delta = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      delta = diff[31:0];
    end

    // Count the redundant sign bits below the sign bit.
    if (delta == '0) begin
      run = 32;
    end else begin
      run = 0;
      for (int b = 30; b >= 0; b--) begin
        if (delta[b] != delta[31]) break;
        run++;
      end
    end

    if (mode == '0 && run > 26) begin
      append_byte({2'b11, delta[5:0]});
    end else if (mode == '0 && run > 18) begin
      append_byte({2'b10, delta[13:8]});
      append_byte(delta[7:0]);
    end else if (mode == '0 && run > 10) begin
      append_byte({2'b01, delta[21:16]});
      append_byte(delta[15:8]);
      append_byte(delta[7:0]);
    end else begin
      append_byte({2'b00, mode});
      append_byte(smp[31:24]);
      append_byte(smp[23:16]);
      append_byte(smp[15:8]);
      append_byte(smp[7:0]);
    end
    if (coded_words.size() > 0) coded_words[coded_words.size()-1].last = 1'b1;
  endtask

  // Checks outgoing words and records the expected words of each accepted item.
  always @(posedge clk) begin : word_checker
    fifo_entry_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: packed_word %h, last %b",
                 out_bus.packed_word, out_bus.last);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_bus.packed_word !== want.word) begin
            $error("packed_word: expected %h, actual %h", want.word, out_bus.packed_word);
            error_count++;
          end
          if (out_bus.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_bus.last);
            error_count++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        encode_sample(in_bus.operation, in_bus.channel, in_bus.sample, in_bus.record_mode);
        if (item_typed) begin
          if (item_n_words != 2'd0) begin
            want.word = item_word;
            want.last = 1'b1;
            expected_words.push_back(want);
          end
        end else begin
          foreach (coded_words[k]) expected_words.push_back(coded_words[k]);
        end
      end
    end
  end

  // The receiver cycles through always ready, light, periodic and heavy stalls.
  always @(posedge clk) begin
    case ((cycle_count / 256) % 4)
      0:       out_bus.ready <= 1'b1;
      1:       out_bus.ready <= ($urandom_range(0, 3) != 0);
      2:       out_bus.ready <= (cycle_count % 3 == 0);
      default: out_bus.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Offers one item and holds it until the block takes it.
  task automatic send_item(input stim_row_t row);
    in_bus.valid       <= 1'b1;
    in_bus.operation   <= row.op;
    in_bus.channel     <= row.ch;
    in_bus.sample      <= row.smp;
    in_bus.record_mode <= row.mode;
    item_typed         <= row.typed;
    item_n_words       <= row.n_words;
    item_word          <= row.word;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Stimulus: directed rows, then random items sent in bursts.
  initial begin
    logic [31:0] sent_history [DVWP_CHANNELS];
    stim_row_t   row;
    int          burst_left;
    int          gap;
    int          pick;
    int          delta;
    in_bus.valid       = 1'b0;
    in_bus.operation   = OP_PUSH;
    in_bus.channel     = '0;
    in_bus.sample      = '0;
    in_bus.record_mode = '0;
    item_typed         = 1'b0;
    item_n_words       = 2'd0;
    item_word          = '0;
    held_count         = 2'd0;
    held_bytes         = '0;
    foreach (chan_history[k]) chan_history[k] = '0;
    foreach (sent_history[k]) sent_history[k] = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < DIRECTED_ROWS + RANDOM_ITEMS; i++) begin
      if (i < DIRECTED_ROWS) begin
        row = directed_rows[i];
      end else begin
        // Let the output drain completely once, halfway through.
        if (i == DIRECTED_ROWS + RANDOM_ITEMS / 2) begin
          if (in_bus.valid) in_bus.valid <= 1'b0;
          @(posedge clk);
          while (expected_words.size() != 0) @(posedge clk);
        end
        row         = '0;
        row.op      = ($urandom_range(0, 49) == 0) ? OP_RESTART : OP_PUSH;
        row.ch      = CHAN_W'($urandom_range(0, DVWP_CHANNELS - 1));
        row.mode    = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(1, 63)) : '0;
        // Deltas are aimed at each record length, with some raw and extreme samples.
        pick = $urandom_range(0, 99);
        if (pick < 30)      delta = int'($urandom) >>> $urandom_range(25, 31);
        else if (pick < 55) delta = int'($urandom) >>> $urandom_range(17, 25);
        else if (pick < 75) delta = int'($urandom) >>> $urandom_range(9, 17);
        else                delta = int'($urandom) >>> $urandom_range(0, 9);
        if (pick >= 85 && pick < 92) row.smp = $urandom;
        else if (pick >= 92) row.smp = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else row.smp = sent_history[row.ch] + delta;
      end

      if (row.op == OP_RESTART) begin
        foreach (sent_history[k]) sent_history[k] = '0;
      end else begin
        sent_history[row.ch] = row.smp;
      end
      send_item(row);

      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
    end
    if (in_bus.valid) in_bus.valid <= 1'b0;

    // Let the last item's words be queued before checking for drain.
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

endmodule
